// File: rtl/rvg_pkg.sv
// Package for the radial vignetting gain block: widths, register codes, helpers.
package rvg_pkg;

  // Stream and sample widths.
  localparam int PIX_W     = 16;
  localparam int COORD_W   = 13;
  localparam int TIDX_W    = 6;
  localparam int TVAL_W    = 16;
  localparam int IN_DATA_W  = 2 * COORD_W + 3 * PIX_W + TIDX_W + TVAL_W;  // 96
  localparam int OUT_DATA_W = 3 * PIX_W;                                  // 48

  // Geometry: Q13.4 centre, distance and sqrt widths.
  localparam int CTR_W  = COORD_W + 4;           // Q13.4
  localparam int SQ_W   = 2 * CTR_W + 1;         // dx^2 + dy^2
  localparam int RAD_W  = SQ_W + 8;              // sum scaled to Q.8 squared
  localparam int ROOT_W = (RAD_W + 1) / 2;       // distance, Q.8
  localparam int TRY_W  = RAD_W + 2;             // sqrt trial value

  // Radius scaling.
  localparam int INV_W   = 32;                   // Q2.30
  localparam int PROD_W  = ROOT_W + INV_W;
  localparam int R_SHIFT = 22;
  localparam int FRAC_W  = 16;
  localparam int R_W     = FRAC_W + 1;           // 0 .. 1.0 in Q1.16
  localparam logic [R_W-1:0] R_ONE = R_W'(1) << FRAC_W;

  // Gain curve.
  localparam int GAIN_ENTRIES = 64;
  localparam int IDX_W   = $clog2(GAIN_ENTRIES);
  localparam int POS_W   = FRAC_W + IDX_W;
  localparam int GAIN_W  = 16;                   // Q4.12
  localparam int GAIN_FRAC = 12;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(GAIN_ENTRIES - 1);

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int CFG_W  = 32;

  typedef enum logic [1:0] {
    REG_ENABLE     = 2'd0,
    REG_CENTER_X   = 2'd1,
    REG_CENTER_Y   = 2'd2,
    REG_INV_RADIUS = 2'd3
  } reg_idx_e;

  // Opcode carried on the input tuser.
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_TABLE = 1'b1
  } opcode_e;

  // Item fields that ride along the pipeline.
  typedef struct packed {
    logic              pix;   // 1: pixel, 0: table write
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic [TIDX_W-1:0] tidx;
    logic [TVAL_W-1:0] tval;
  } item_t;

  // Round a Q4.12 product to an integer sample and saturate it.
  function automatic logic [PIX_W-1:0] round_sat(input logic [PIX_W+GAIN_W-1:0] prod);
    logic [PIX_W+GAIN_W:0]             rnd;
    logic [PIX_W+GAIN_W-GAIN_FRAC:0]   val;
    rnd = (PIX_W+GAIN_W+1)'(prod) + (PIX_W+GAIN_W+1)'(1 << (GAIN_FRAC - 1));
    val = rnd[PIX_W+GAIN_W:GAIN_FRAC];
    if (|val[PIX_W+GAIN_W-GAIN_FRAC:PIX_W]) begin
      round_sat = '1;
    end else begin
      round_sat = val[PIX_W-1:0];
    end
  endfunction

endpackage

// File: rtl/radial_vignetting_gain.sv
// Radial vignetting gain: pipelined lens shading correction on an RGB pixel stream.
//
//  channel   | dir | handshake                 | payload
//  ----------+-----+---------------------------+------------------------------------
//  s_axis    | in  | tvalid / tready           | tuser opcode, tdata item fields
//  m_axis    | out | tvalid / tready           | tdata corrected red, green, blue
//  apb       | in  | psel / penable / pready   | paddr, pwdata, prdata, 4 registers
//
//  One transaction is taken per cycle unless the output stalls. The pipeline depth
//  is set by the square root, one result bit per stage (22 stages).
//  Table writes take effect in stream order at the table stage and give no result.
//  All stages move on one enable, held back only when the output register is full
//  and not taken; a stall freezes every stage. Reset clears valid bits and config registers.
module radial_vignetting_gain (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [12:0] pixel_x, [25:13] pixel_y, [41:26] red_in, [57:42] green_in,
  // [73:58] blue_in, [79:74] table_index, [95:80] table_value
  input  logic [rvg_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] opcode
  input  logic                            s_axis_tuser,
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] red_out, [31:16] green_out, [47:32] blue_out
  output logic [rvg_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rvg_pkg::ADDR_W-1:0]      paddr,
  input  logic [rvg_pkg::CFG_W-1:0]       pwdata,
  output logic [rvg_pkg::CFG_W-1:0]       prdata,
  output logic                            pready
);

  localparam int SQ_STEPS = rvg_pkg::ROOT_W;
  localparam int S_DIFF   = 1;
  localparam int S_SQR    = S_DIFF + 1;
  localparam int S_RAD    = S_SQR + 1;
  localparam int S_DIST   = S_RAD + SQ_STEPS;
  localparam int S_SCALE  = S_DIST + 1;
  localparam int S_POS    = S_SCALE + 1;
  localparam int S_TAB    = S_POS + 1;
  localparam int S_WGT    = S_TAB + 1;
  localparam int S_GAIN   = S_WGT + 1;
  localparam int S_MUL    = S_GAIN + 1;
  localparam int S_OUT    = S_MUL + 1;

  // ---------------------------------------------------------------- config
  logic                        enable_q;
  logic [rvg_pkg::CTR_W-1:0]   center_x_q;
  logic [rvg_pkg::CTR_W-1:0]   center_y_q;
  logic [rvg_pkg::INV_W-1:0]   inv_radius_q;
  logic                        cfg_wr;
  rvg_pkg::reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = rvg_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      center_x_q   <= '0;
      center_y_q   <= '0;
      inv_radius_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rvg_pkg::REG_ENABLE:     enable_q     <= pwdata[0];
        rvg_pkg::REG_CENTER_X:   center_x_q   <= pwdata[rvg_pkg::CTR_W-1:0];
        rvg_pkg::REG_CENTER_Y:   center_y_q   <= pwdata[rvg_pkg::CTR_W-1:0];
        rvg_pkg::REG_INV_RADIUS: inv_radius_q <= pwdata[rvg_pkg::INV_W-1:0];
        default:                 enable_q     <= enable_q;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      rvg_pkg::REG_ENABLE:     prdata = rvg_pkg::CFG_W'(enable_q);
      rvg_pkg::REG_CENTER_X:   prdata = rvg_pkg::CFG_W'(center_x_q);
      rvg_pkg::REG_CENTER_Y:   prdata = rvg_pkg::CFG_W'(center_y_q);
      rvg_pkg::REG_INV_RADIUS: prdata = rvg_pkg::CFG_W'(inv_radius_q);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  logic                  adv;
  logic                  vld_q [1:S_OUT];
  rvg_pkg::item_t        item_q [1:S_OUT];
  rvg_pkg::item_t        in_item;

  assign m_axis_tvalid = vld_q[S_OUT] && item_q[S_OUT].pix;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  assign in_item.pix   = (rvg_pkg::opcode_e'(s_axis_tuser) == rvg_pkg::OP_PIXEL);
  assign in_item.red   = s_axis_tdata[41:26];
  assign in_item.green = s_axis_tdata[57:42];
  assign in_item.blue  = s_axis_tdata[73:58];
  assign in_item.tidx  = s_axis_tdata[79:74];
  assign in_item.tval  = s_axis_tdata[95:80];

  // valid bits move with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= S_OUT; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[1] <= s_axis_tvalid;
      for (int i = 2; i <= S_OUT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      item_q[1] <= in_item;
      for (int i = 2; i <= S_OUT; i++) item_q[i] <= item_q[i-1];
    end
  end

  // ---------------------------------------------------------------- distance
  logic [rvg_pkg::CTR_W-1:0]  px, py, dx_d, dy_d, dx_q, dy_q;
  logic [2*rvg_pkg::CTR_W-1:0] dx2_q, dy2_q;
  logic [rvg_pkg::SQ_W-1:0]   sum;

  // pixel centre in Q13.4, absolute offset from the optical centre
  assign px   = {s_axis_tdata[12:0], 4'b1000};
  assign py   = {s_axis_tdata[25:13], 4'b1000};
  assign dx_d = (px >= center_x_q) ? px - center_x_q : center_x_q - px;
  assign dy_d = (py >= center_y_q) ? py - center_y_q : center_y_q - py;
  assign sum  = rvg_pkg::SQ_W'(dx2_q) + rvg_pkg::SQ_W'(dy2_q);

  logic [rvg_pkg::RAD_W-1:0]  rem_q  [0:SQ_STEPS];
  logic [rvg_pkg::ROOT_W-1:0] root_q [0:SQ_STEPS];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q      <= dx_d;
      dy_q      <= dy_d;
      dx2_q     <= dx_q * dx_q;
      dy2_q     <= dy_q * dy_q;
      rem_q[0]  <= {sum, 8'd0};
      root_q[0] <= '0;
    end
  end

  // square root, one result bit per stage; rem holds value minus root squared
  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sqrt
    localparam int K = rvg_pkg::ROOT_W - 1 - s;
    logic [rvg_pkg::TRY_W-1:0] trial;
    logic                      take;
    assign trial = (rvg_pkg::TRY_W'(root_q[s]) << (K + 1))
                 + (rvg_pkg::TRY_W'(1) << (2 * K));
    assign take  = rvg_pkg::TRY_W'(rem_q[s]) >= trial;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (take) begin
          rem_q[s+1]  <= rem_q[s] - trial[rvg_pkg::RAD_W-1:0];
          root_q[s+1] <= root_q[s] | (rvg_pkg::ROOT_W'(1) << K);
        end else begin
          rem_q[s+1]  <= rem_q[s];
          root_q[s+1] <= root_q[s];
        end
      end
    end
  end

  // ---------------------------------------------------------------- radius to position
  logic [rvg_pkg::PROD_W-1:0] scale_q;
  logic [rvg_pkg::INV_W-1:0]  r_raw;
  logic [rvg_pkg::R_W-1:0]    r_clamp;
  logic [rvg_pkg::POS_W-1:0]  pos_q;

  assign r_raw   = scale_q[rvg_pkg::R_SHIFT +: rvg_pkg::INV_W];
  assign r_clamp = (r_raw > rvg_pkg::INV_W'(rvg_pkg::R_ONE)) ? rvg_pkg::R_ONE
                                                              : r_raw[rvg_pkg::R_W-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      scale_q <= rvg_pkg::PROD_W'(root_q[SQ_STEPS]) * rvg_pkg::PROD_W'(inv_radius_q);
      pos_q   <= rvg_pkg::POS_W'(r_clamp) * rvg_pkg::POS_W'(rvg_pkg::GAIN_ENTRIES - 1);
    end
  end

  // ---------------------------------------------------------------- gain curve memory
  logic [rvg_pkg::GAIN_W-1:0] gain_mem_q [rvg_pkg::GAIN_ENTRIES];
  logic [rvg_pkg::IDX_W-1:0]  idx_a, idx_b;
  logic [rvg_pkg::GAIN_W-1:0] ta_q, tb_q;
  logic [rvg_pkg::FRAC_W-1:0] frac_q;
  logic                       tab_wr;

  // last entry pairs with itself; its fraction is always zero
  assign idx_a  = pos_q[rvg_pkg::POS_W-1:rvg_pkg::FRAC_W];
  assign idx_b  = (idx_a == rvg_pkg::IDX_LAST) ? idx_a : idx_a + 1'b1;
  assign tab_wr = adv && vld_q[S_POS] && !item_q[S_POS].pix;

  always_ff @(posedge clk_i) begin
    if (tab_wr) begin
      gain_mem_q[item_q[S_POS].tidx[rvg_pkg::IDX_W-1:0]] <= item_q[S_POS].tval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ta_q   <= gain_mem_q[idx_a];
      tb_q   <= gain_mem_q[idx_b];
      frac_q <= pos_q[rvg_pkg::FRAC_W-1:0];
    end
  end

  // ---------------------------------------------------------------- interpolation
  logic [rvg_pkg::GAIN_W+rvg_pkg::R_W-1:0]    wa_q;
  logic [rvg_pkg::GAIN_W+rvg_pkg::FRAC_W-1:0] wb_q;
  logic [rvg_pkg::GAIN_W+rvg_pkg::R_W-1:0]    wsum;
  logic [rvg_pkg::GAIN_W-1:0]                 gain_q;

  assign wsum = wa_q + (rvg_pkg::GAIN_W+rvg_pkg::R_W)'(wb_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wa_q     <= (rvg_pkg::GAIN_W+rvg_pkg::R_W)'(ta_q)
                * (rvg_pkg::GAIN_W+rvg_pkg::R_W)'(rvg_pkg::R_ONE - rvg_pkg::R_W'(frac_q));
      wb_q     <= (rvg_pkg::GAIN_W+rvg_pkg::FRAC_W)'(tb_q)
                * (rvg_pkg::GAIN_W+rvg_pkg::FRAC_W)'(frac_q);
      gain_q   <= wsum[rvg_pkg::FRAC_W +: rvg_pkg::GAIN_W];
    end
  end

  // ---------------------------------------------------------------- apply gain
  logic [rvg_pkg::PIX_W+rvg_pkg::GAIN_W-1:0] mr_q, mg_q, mb_q;
  logic [rvg_pkg::OUT_DATA_W-1:0]            out_q;
  rvg_pkg::item_t                            it_mul;

  assign it_mul = item_q[S_MUL];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mr_q <= item_q[S_GAIN].red   * gain_q;
      mg_q <= item_q[S_GAIN].green * gain_q;
      mb_q <= item_q[S_GAIN].blue  * gain_q;
      if (enable_q) begin
        out_q <= {rvg_pkg::round_sat(mb_q), rvg_pkg::round_sat(mg_q),
                  rvg_pkg::round_sat(mr_q)};
      end else begin
        out_q <= {it_mul.blue, it_mul.green, it_mul.red};
      end
    end
  end

  assign m_axis_tdata = out_q;

`ifndef SYNTHESIS
  // square root leaves a remainder no larger than twice the root
  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[S_DIST] |-> ({1'b0, rem_q[SQ_STEPS]} <=
                       (rvg_pkg::RAD_W+1)'({root_q[SQ_STEPS], 1'b0})))
    else $error("sqrt remainder out of range");

  // table position never passes the last curve entry
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[S_POS] |-> (pos_q[rvg_pkg::POS_W-1:rvg_pkg::FRAC_W] <= rvg_pkg::IDX_LAST))
    else $error("curve index beyond table");

  // a stall freezes the inner stages
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(vld_q[S_TAB]) && $stable(vld_q[S_DIST])))
    else $error("pipeline moved during stall");

  // fraction feeding the weights is zero whenever the last entry is addressed
  a_last_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[S_POS] && adv && idx_a == rvg_pkg::IDX_LAST)
      |=> (frac_q == '0))
    else $error("nonzero fraction at last entry");
`endif

endmodule
